[hdl/bkh_pkg.sv]
package bkh_pkg;

    localparam logic [31:0] GOLDEN          = 32'h9e3779b9;
    localparam int          BLOCK_LEN       = 12;
    localparam int          FILL_W          = 4;
    localparam int          MIX_LINES       = 9;
    localparam int          LINE_W          = 4;
    localparam int          DEFAULT_BUCKETS = 256;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [7:0]  bucket_index;
    } t_out_req;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    function automatic logic [4:0] mix_shift(input logic [LINE_W-1:0] line);
        logic [4:0] sh;
        case (line)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

    // One line of the mixer: the word being updated loses the other two and
    // takes in a shifted copy of the word updated last.
    function automatic t_abc mix_line(input t_abc s, input logic [LINE_W-1:0] line);
        t_abc       r;
        logic [4:0] sh;
        r  = s;
        sh = mix_shift(line);
        case (line)
            4'd0, 4'd3, 4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> sh);
            4'd1, 4'd4, 4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << sh);
            4'd2, 4'd5, 4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> sh);
            default:          r = s;
        endcase
        return r;
    endfunction

endpackage

[hdl/byte_key_hash_bucket_select.sv]
// Byte-serial key hash with bucket select.
// The input channel takes one key byte per request; has_byte marks a real byte
// and last_byte ends the key. A request with last_byte set produces one result
// request carrying the 32-bit hash and its bucket index; other requests produce
// none. The configuration channel writes the starting value of the third mixing
// word; it takes effect at once when no byte of the current key has been taken,
// otherwise from the next key. It is always ready.
// One input request is taken every cycle while the skid register is empty.
// A result passes through an input register, a nine-stage mixer pipeline for
// full 12-byte blocks, a stage that adds the length and the tail, a second
// nine-stage mixer pipeline for the final mix, and the output register.
// Block mixes of one key are at least 12 bytes apart, so each one leaves the
// first mixer before the next block of the same key needs its result.
// Reset clears the key state and the pipeline and sets the init value to zero.
// When the receiver stalls, one more result is caught in a skid register; after
// that the whole pipeline and the input channel stop until the output drains.
module byte_key_hash_bucket_select
    import bkh_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req
);

    localparam logic [31:0] BucketMask = 32'(BUCKETS - 1);

    typedef struct packed {
        logic        do_mix;
        logic        is_end;
        logic        from_hold;
        t_abc        s;
        logic [31:0] ta;
        logic [31:0] tb;
        logic [31:0] tc;
        logic [31:0] len;
    } t_job;

    // Key state
    logic [31:0]                 r_init;
    logic [31:0]                 r_c0;
    logic [FILL_W-1:0]           r_fill;
    logic [31:0]                 r_len;
    logic                        r_mixed;
    logic                        r_open;
    logic [BLOCK_LEN-1:0][7:0]   r_blk;
    t_abc                        r_hold;

    // Pipeline
    logic                        r_j_v;
    t_job                        r_j;
    logic [MIX_LINES-1:0]        r_m1_v;
    t_job                        r_m1 [MIX_LINES];
    logic                        r_k_v;
    t_abc                        r_k;
    logic [MIX_LINES-1:0]        r_m2_v;
    t_abc                        r_m2 [MIX_LINES];
    logic                        r_out_v;
    t_out_req                    r_out;
    logic                        r_skid_v;
    t_out_req                    r_skid;

    logic                        w_en;
    logic                        w_in_acc;
    logic                        w_cfg_acc;
    logic                        w_out_take;
    logic                        w_full;
    logic [FILL_W-1:0]           w_fill_inc;
    logic [FILL_W-1:0]           w_tail_fill;
    logic [BLOCK_LEN-1:0][7:0]   w_blk;
    logic [BLOCK_LEN-1:0][7:0]   w_tail;
    logic [31:0]                 w_len_inc;
    t_abc                        w_base;
    t_abc                        w_k_base;
    t_job                        n_j;
    t_job                        n_m1 [MIX_LINES];
    t_abc                        n_k;
    t_abc                        n_m2 [MIX_LINES];
    t_out_req                    n_fin;
    logic [MIX_LINES-1:0]        w_m1_busy;

    assign w_en        = !r_skid_v;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && w_en;
    assign w_cfg_acc   = i_cfg_valid;
    assign w_out_take  = r_out_v && i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_out_req   = r_out;

    // Front end: place the byte, and build a block job, an end job or both.
    always_comb begin
        w_blk = r_blk;
        for (int i = 0; i < BLOCK_LEN; i++) begin
            if (i_in_req.has_byte && r_fill == FILL_W'(i)) begin
                w_blk[i] = i_in_req.key_byte;
            end
        end
        w_full      = i_in_req.has_byte && (r_fill == FILL_W'(BLOCK_LEN - 1));
        w_fill_inc  = r_fill + FILL_W'(i_in_req.has_byte);
        w_tail_fill = w_full ? '0 : w_fill_inc;
        for (int i = 0; i < BLOCK_LEN; i++) begin
            w_tail[i] = (FILL_W'(i) < w_tail_fill) ? w_blk[i] : 8'h00;
        end
        w_len_inc = r_len + 32'(i_in_req.has_byte);
        w_base    = r_mixed ? r_hold : t_abc'{a: GOLDEN, b: GOLDEN, c: r_c0};

        n_j.do_mix    = w_full;
        n_j.is_end    = i_in_req.last_byte;
        // An end job without a block of its own, of a key that already mixed a
        // block, takes that block's result when it leaves the first mixer.
        n_j.from_hold = r_mixed && !w_full;
        n_j.s         = w_base;
        if (w_full) begin
            n_j.s.a = w_base.a + w_blk[3:0];
            n_j.s.b = w_base.b + w_blk[7:4];
            n_j.s.c = w_base.c + w_blk[11:8];
        end
        n_j.ta  = w_tail[3:0];
        n_j.tb  = w_tail[7:4];
        n_j.tc  = {w_tail[10:8], 8'h00};
        n_j.len = w_len_inc;
    end

    // First mixer: one line per stage, jobs without a block pass unchanged.
    always_comb begin
        for (int i = 0; i < MIX_LINES; i++) begin
            n_m1[i] = (i == 0) ? r_j : r_m1[(i == 0) ? 0 : i - 1];
            if (n_m1[i].do_mix) begin
                n_m1[i].s = mix_line(n_m1[i].s, LINE_W'(i));
            end
            w_m1_busy[i] = r_m1_v[i] && r_m1[i].do_mix;
        end
    end

    // Length and tail are added on the way into the final mix.
    always_comb begin
        w_k_base = r_m1[MIX_LINES-1].from_hold ? r_hold : r_m1[MIX_LINES-1].s;
        n_k.a    = w_k_base.a + r_m1[MIX_LINES-1].ta;
        n_k.b    = w_k_base.b + r_m1[MIX_LINES-1].tb;
        n_k.c    = w_k_base.c + r_m1[MIX_LINES-1].len + r_m1[MIX_LINES-1].tc;
    end

    always_comb begin
        for (int i = 0; i < MIX_LINES; i++) begin
            n_m2[i] = mix_line((i == 0) ? r_k : r_m2[(i == 0) ? 0 : i - 1], LINE_W'(i));
        end
        n_fin.hash_value   = r_m2[MIX_LINES-1].c;
        n_fin.bucket_index = 8'(r_m2[MIX_LINES-1].c & BucketMask);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_c0     <= '0;
            r_fill   <= '0;
            r_len    <= '0;
            r_mixed  <= 1'b0;
            r_open   <= 1'b0;
            r_j_v    <= 1'b0;
            r_m1_v   <= '0;
            r_k_v    <= 1'b0;
            r_m2_v   <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                r_init <= i_cfg_data;
                // A key that ends in this cycle re-arms with the new value too.
                if (!r_open || (w_in_acc && i_in_req.last_byte)) begin
                    r_c0 <= i_cfg_data;
                end
            end
            if (w_in_acc) begin
                if (i_in_req.last_byte) begin
                    r_fill  <= '0;
                    r_len   <= '0;
                    r_mixed <= 1'b0;
                    r_open  <= 1'b0;
                    if (!w_cfg_acc) begin
                        r_c0 <= r_init;
                    end
                end else begin
                    r_fill  <= w_tail_fill;
                    r_len   <= w_len_inc;
                    r_mixed <= r_mixed || w_full;
                    r_open  <= r_open || i_in_req.has_byte;
                end
            end
            if (w_en) begin
                r_j_v  <= w_in_acc && (w_full || i_in_req.last_byte);
                r_m1_v <= {r_m1_v[MIX_LINES-2:0], r_j_v};
                r_k_v  <= r_m1_v[MIX_LINES-1] && r_m1[MIX_LINES-1].is_end;
                r_m2_v <= {r_m2_v[MIX_LINES-2:0], r_k_v};
                if (r_m2_v[MIX_LINES-1]) begin
                    if (!r_out_v || i_out_ready) begin
                        r_out_v <= 1'b1;
                    end else begin
                        r_skid_v <= 1'b1;
                    end
                end else if (w_out_take) begin
                    r_out_v <= 1'b0;
                end
            end else if (w_out_take) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_blk <= w_blk;
        end
        if (w_en) begin
            r_j <= n_j;
            for (int i = 0; i < MIX_LINES; i++) begin
                r_m1[i] <= n_m1[i];
                r_m2[i] <= n_m2[i];
            end
            r_k <= n_k;
            if (r_m1_v[MIX_LINES-1] && r_m1[MIX_LINES-1].do_mix) begin
                r_hold <= r_m1[MIX_LINES-1].s;
            end
            if (r_m2_v[MIX_LINES-1]) begin
                if (!r_out_v || i_out_ready) begin
                    r_out <= n_fin;
                end else begin
                    r_skid <= n_fin;
                end
            end
        end else if (w_out_take) begin
            r_out <= r_skid;
        end
    end

`ifndef SYNTHESIS
    // A block that enters the mixer must find no earlier block still in it.
    a_block_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_j_v && r_j.do_mix && w_en) |-> (w_m1_busy == '0))
        else $error("block job entered while another block mix was in flight");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready && r_m2_v[MIX_LINES-1]))
        else $error("skid register filled without a stalled output");

    a_end_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_m1_v[MIX_LINES-1] && !r_m1[MIX_LINES-1].is_end) |=> !r_k_v)
        else $error("block job went on to the final mix");
`endif

endmodule

[tb/sv/key_hash_check_pkg.sv]
package key_hash_check_pkg;
    import bkh_pkg::*;

    localparam int BUCKET_COUNT = DEFAULT_BUCKETS;

    class hash_scoreboard;
        logic [31:0] init_word;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] key_len;
        logic [7:0]  held [BLOCK_LEN];
        int unsigned fill;
        bit          key_started;
        t_out_req    pending_hashes[$];
        int unsigned errors;
        int unsigned keys_done;
        int unsigned bytes_seen;
        int unsigned blocks_mixed;
        int unsigned hashes_checked;

        function new();
            init_word      = '0;
            errors         = 0;
            keys_done      = 0;
            bytes_seen     = 0;
            blocks_mixed   = 0;
            hashes_checked = 0;
            foreach (held[i]) held[i] = '0;
            restart_key();
        endfunction

        function void restart_key();
            word_a      = GOLDEN;
            word_b      = GOLDEN;
            word_c      = init_word;
            fill        = 0;
            key_len     = '0;
            key_started = 1'b0;
        endfunction

        // A new init value reaches the third word only when no byte of the
        // current key has been taken yet.
        function void set_init(input logic [31:0] value);
            init_word = value;
            if (!key_started) word_c = value;
        endfunction

        function void mix_words();
            logic [31:0] a, b, c;
            a = word_a;
            b = word_b;
            c = word_c;
            a = (a - b - c) ^ (c >> 13);
            b = (b - c - a) ^ (a << 8);
            c = (c - a - b) ^ (b >> 13);
            a = (a - b - c) ^ (c >> 12);
            b = (b - c - a) ^ (a << 16);
            c = (c - a - b) ^ (b >> 5);
            a = (a - b - c) ^ (c >> 3);
            b = (b - c - a) ^ (a << 10);
            c = (c - a - b) ^ (b >> 15);
            word_a = a;
            word_b = b;
            word_c = c;
        endfunction

        function void take_byte_request(input t_in_req r);
            logic [31:0] v;
            logic [31:0] masked;
            t_out_req    res;
            if (r.has_byte) begin
                held[fill] = r.key_byte;
                fill++;
                key_len++;
                key_started = 1'b1;
                bytes_seen++;
                if (fill == BLOCK_LEN) begin
                    word_a += {held[3], held[2], held[1], held[0]};
                    word_b += {held[7], held[6], held[5], held[4]};
                    word_c += {held[11], held[10], held[9], held[8]};
                    mix_words();
                    blocks_mixed++;
                    fill = 0;
                end
            end
            if (r.last_byte) begin
                word_c += key_len;
                // The low byte of the third word is kept for the length.
                for (int i = 0; i < fill; i++) begin
                    v = {24'd0, held[i]};
                    if (i < 4)      word_a += v << (8 * i);
                    else if (i < 8) word_b += v << (8 * (i - 4));
                    else            word_c += v << (8 * (i - 7));
                end
                mix_words();
                masked           = word_c & 32'(BUCKET_COUNT - 1);
                res.hash_value   = word_c;
                res.bucket_index = masked[7:0];
                pending_hashes.push_back(res);
                keys_done++;
                restart_key();
            end
        endfunction

        function void check_hash(input t_out_req got);
            t_out_req want;
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected result hash=%h bucket=%h",
                         $time, got.hash_value, got.bucket_index);
                errors++;
                return;
            end
            want = pending_hashes.pop_front();
            hashes_checked++;
            if (got.hash_value !== want.hash_value) begin
                $display("%0t: hash_value mismatch, expected %h, actual %h",
                         $time, want.hash_value, got.hash_value);
                errors++;
            end
            if (got.bucket_index !== want.bucket_index) begin
                $display("%0t: bucket_index mismatch, expected %h, actual %h",
                         $time, want.bucket_index, got.bucket_index);
                errors++;
            end
        endfunction

        function int unsigned pending_count();
            return pending_hashes.size();
        endfunction
    endclass

endpackage

[tb/sv/testbench.sv]
module testbench;
    import bkh_pkg::*;
    import key_hash_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY     = 20;
    localparam int SETTLE_CYCLES    = PIPE_LATENCY + 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 4000;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_REQUESTS   = 235;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_req     in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_req    out_req;

    hash_scoreboard sb = new();

    int unsigned requests_sent = 0;
    int unsigned init_writes = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    bit          long_hold_req = 1'b0;

    byte_key_hash_bucket_select #(
        .BUCKETS(BUCKET_COUNT)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_req  (out_req)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic t_in_req make_req(input logic [7:0] b, input logic h,
                                         input logic l);
        t_in_req r;
        r.key_byte  = b;
        r.has_byte  = h;
        r.last_byte = l;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_key_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)  return 0;
        if (roll < 70) return $urandom_range(1, 30);
        if (roll < 95) return $urandom_range(31, 60);
        return $urandom_range(61, 130);
    endfunction

    task automatic send_request(input t_in_req r);
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        sb.take_byte_request(r);
        if (r.has_byte || r.last_byte) requests_sent++;
    endtask

    // Bursts of back-to-back requests separated by random gaps; a gap of
    // zero joins two bursts into one longer stretch.
    task automatic send_paced(input t_in_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_request(r);
    endtask

    task automatic issue(input t_in_req r, input bit paced);
        if (paced) send_paced(r);
        else       send_request(r);
    endtask

    task automatic send_key(input int unsigned len, input bit end_empty, input bit paced);
        t_in_req r;
        for (int unsigned i = 0; i < len; i++) begin
            if (paced && $urandom_range(0, 9) == 0)
                issue(make_req(pick_byte(), 1'b0, 1'b0), paced);
            r = make_req(pick_byte(), 1'b1, (i == len - 1) && !end_empty);
            issue(r, paced);
        end
        if (len == 0 || end_empty)
            issue(make_req(pick_byte(), 1'b0, 1'b1), paced);
    endtask

    // Stop offering requests, let every hash come back, then give the
    // pipeline time to retire requests that produce no result.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_init(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_init(value);
        init_writes++;
    endtask

    // Receiver: stretches of always-ready, random and mostly-stalled behavior,
    // plus one long hold-off when the stimulus asks for it.
    initial begin
        int unsigned stretch;
        int unsigned mode;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stretch = $urandom_range(16, 64);
            mode    = $urandom_range(0, 2);
            repeat (stretch) begin
                @(posedge clk);
                if (long_hold_req) begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                    long_hold_req = 1'b0;
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_hash(out_req);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d hashes outstanding",
                         $time, quiet_cycles, sb.pending_count());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] init_pick;
        int unsigned target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty keys, an idle request in between, and one-byte keys.
        send_request(make_req(8'h00, 1'b0, 1'b1));
        send_request(make_req(8'hFF, 1'b0, 1'b0));
        send_request(make_req(8'h5A, 1'b0, 1'b1));
        send_request(make_req(8'hFF, 1'b1, 1'b1));
        send_request(make_req(8'h00, 1'b1, 1'b1));
        quiesce();
        write_init(32'hFFFF_FFFF);

        // Exactly one full block, so the tail is empty at the end.
        for (int i = 0; i < BLOCK_LEN; i++)
            send_request(make_req((i % 2) ? 8'hFF : 8'h00, 1'b1, i == BLOCK_LEN - 1));
        // Bytes followed by an end request that carries no byte.
        send_request(make_req(8'h7F, 1'b1, 1'b0));
        send_request(make_req(8'h80, 1'b1, 1'b0));
        send_request(make_req(8'h01, 1'b1, 1'b0));
        send_request(make_req(8'h00, 1'b0, 1'b1));

        // Init write in the middle of a key only counts from the next key.
        send_request(make_req(8'hC3, 1'b1, 1'b0));
        send_request(make_req(8'h3C, 1'b1, 1'b0));
        quiesce();
        write_init(32'h0000_0000);
        send_request(make_req(8'hA5, 1'b1, 1'b1));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       init_pick = 32'hFFFF_FFFF;
                1:       init_pick = 32'h8000_0000;
                2:       init_pick = 32'h0000_0001;
                5:       init_pick = 32'h0000_0000;
                default: init_pick = $urandom;
            endcase
            quiesce();
            write_init(init_pick);
            if (ph == 2) begin
                // Short keys against a stalled receiver fill the pipeline.
                long_hold_req = 1'b1;
                for (int k = 0; k < 60; k++)
                    send_key($urandom_range(0, 2), 1'b0, 1'b0);
                quiesce();
            end
            burst_left = 0;
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target)
                send_key(pick_key_length(), $urandom_range(0, 7) == 0, 1'b1);
        end

        quiesce();
        $display("Hashed %0d keys (%0d bytes, %0d full blocks) under %0d init values;",
                 sb.keys_done, sb.bytes_seen, sb.blocks_mixed, init_writes + 1);
        $display("%0d results checked, %0d mismatches.", sb.hashes_checked, sb.errors);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
